[rtl/core/modbus_spindle_frame_builder_macros.svh]
// Assertion macros shared by the spindle frame builder modules.
// Depends on a clk and an active-high synchronous rst in the using module.
`ifndef MODBUS_SPINDLE_FRAME_BUILDER_MACROS_SVH
`define MODBUS_SPINDLE_FRAME_BUILDER_MACROS_SVH

// Check that holds in the same cycle as its condition.
`define MSFB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that holds in the cycle after its condition.
`define MSFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/msfb_pkg.sv]
// Types, constants and helper functions of the spindle frame builder.
// Used by every module under rtl/core; depends on nothing else.
package msfb_pkg;

  // Command codes.
  localparam logic [2:0] OP_HEARTBEAT = 3'd0;
  localparam logic [2:0] OP_RUN       = 3'd1;
  localparam logic [2:0] OP_STOP      = 3'd2;
  localparam logic [2:0] OP_REVERSE   = 3'd3;
  localparam logic [2:0] OP_SPEED     = 3'd4;

  // Frame geometry: six body bytes, then CRC low and CRC high.
  localparam int unsigned FRAME_BODY_LEN = 6;
  localparam logic [2:0]  IDX_CRC_LO     = 3'd6;
  localparam logic [2:0]  IDX_CRC_HI     = 3'd7;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [15:0] MAX_RPM_RESET  = 16'd24000;
  localparam logic [7:0]  PCT_SATURATED  = 8'd255;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // One command beat.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] rpm;
  } cmd_t;

  // One frame byte beat.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_out_t;

  // Body of a frame, byte 0 in element 0.
  typedef logic [FRAME_BODY_LEN-1:0][7:0] body_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Builds the six body bytes for a valid command.
  function automatic body_t frame_body(input logic [2:0] op, input logic [7:0] pct);
    body_t b;
    b[0] = 8'h01;
    b[1] = 8'h06;
    b[2] = 8'h20;
    b[3] = 8'h00;
    b[4] = 8'h00;
    b[5] = 8'h00;
    case (op)
      OP_HEARTBEAT: begin
        b[1] = 8'h03;
        b[2] = 8'h80;
        b[5] = 8'h01;
      end
      OP_RUN:     b[5] = 8'h01;
      OP_STOP:    b[5] = 8'h06;
      OP_REVERSE: b[5] = 8'h02;
      OP_SPEED: begin
        b[2] = 8'h10;
        b[3] = 8'h02;
        b[4] = pct;
      end
      default: b[5] = 8'h00;
    endcase
    return b;
  endfunction

  // Folds one byte into a CRC-16/Modbus, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/msfb_front.sv]
// Front end: accepts commands, computes the speed percentage with a
// bit-serial divider and pushes the six-byte frame body. Uses msfb_pkg.
module msfb_front import msfb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  cmd_t      in_data,
  input  logic [15:0] max_rpm,
  output logic      push,
  output body_t     push_body,
  input  q_status_t q_status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  logic [1:0]  state;
  logic [2:0]  op;
  logic [23:0] num;
  logic [23:0] dsh;
  logic [2:0]  cnt;
  logic [7:0]  pct;
  logic        accept;
  logic        ge;
  logic [23:0] num_start;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Numerator 200*rpm + max_rpm; the divisor is 2*max_rpm.
  assign num_start = {1'b0, in_data.rpm, 7'b0} + {2'b0, in_data.rpm, 6'b0}
                   + {5'b0, in_data.rpm, 3'b0} + {8'b0, max_rpm};

  assign ge = (num >= dsh);

  // The body is composed while waiting for room in the queue.
  assign push      = (state == ST_PUSH) && !q_status.full;
  assign push_body = frame_body(op, pct);

  // Command sequencer and restoring divider, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            op  <= in_data.opcode;
            num <= num_start;
            dsh <= {max_rpm, 8'b0};
            pct <= '0;
            case (in_data.opcode)
              OP_SPEED: state <= ST_SAT;
              OP_HEARTBEAT, OP_RUN, OP_STOP, OP_REVERSE: state <= ST_PUSH;
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_SAT: begin
          // A quotient of 256 or more saturates; this also covers max_rpm of zero.
          if ({1'b0, num} >= {dsh, 1'b0}) begin
            pct   <= PCT_SATURATED;
            state <= ST_PUSH;
          end else begin
            cnt   <= 3'd7;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (ge) begin
            num <= num - dsh;
          end
          pct <= {pct[6:0], ge};
          dsh <= dsh >> 1;
          cnt <= cnt - 3'd1;
          if (cnt == 3'd0) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/msfb_fifo.sv]
// Short queue of frame bodies between the front end and the emitter.
// Uses msfb_pkg and the shared assertion macros.
`include "modbus_spindle_frame_builder_macros.svh"
module msfb_fifo import msfb_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  body_t     push_body,
  input  logic      pop,
  output body_t     head,
  output q_status_t q_status
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  body_t         entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head           = entries[rd_ptr];
  assign q_status.full  = (count == CW'(DEPTH));
  assign q_status.empty = (count == '0);

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_body;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `MSFB_ASSERT_NOW(a_no_overflow, push, !q_status.full, "push into a full queue")
  `MSFB_ASSERT_NOW(a_no_underflow, pop, !q_status.empty, "pop from an empty queue")
  `MSFB_ASSERT_NOW(a_count_range, 1'b1, count <= CW'(DEPTH), "fill count above depth")

endmodule

[rtl/core/msfb_back.sv]
// Back end: takes frame bodies from the queue, emits one byte a beat and
// folds each body byte into the CRC as it goes out. Uses msfb_pkg and the macros.
`include "modbus_spindle_frame_builder_macros.svh"
module msfb_back import msfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_status_t  q_status,
  input  body_t      head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output frame_out_t out_data
);

  logic        busy;
  logic [2:0]  idx;
  logic [15:0] crc;
  body_t       body;
  logic        load;
  logic        in_body;
  logic [7:0]  cur_byte;

  // The output register can take a new byte when empty or being taken.
  assign load    = !out_valid || !out_stall;
  assign in_body = (idx < 3'(FRAME_BODY_LEN));
  assign pop     = load && (!busy || (idx == IDX_CRC_HI)) && !q_status.empty;

  // Byte selection for the current position in the frame.
  always_comb begin
    if (in_body) begin
      cur_byte = body[idx];
    end else if (idx == IDX_CRC_LO) begin
      cur_byte = crc[7:0];
    end else begin
      cur_byte = crc[15:8];
    end
  end

  // Emitter sequence; a new body is taken while the last byte goes out.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      if (busy) begin
        out_valid           <= 1'b1;
        out_data.frame_byte <= cur_byte;
        out_data.last_byte  <= (idx == IDX_CRC_HI);
      end else begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        body <= head;
        crc  <= CRC_INIT;
        idx  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (in_body) begin
          crc <= crc_byte(crc, cur_byte);
        end
        idx <= idx + 3'd1;
        if (idx == IDX_CRC_HI) begin
          busy <= 1'b0;
        end
      end
    end
  end

  `MSFB_ASSERT_NOW(a_last_wraps, out_valid && out_data.last_byte, idx == '0,
                   "last byte out but frame position not reset")
  `MSFB_ASSERT_NOW(a_mid_frame_valid, busy && (idx != '0), out_valid,
                   "mid-frame with no byte on the output")
  `MSFB_ASSERT_NEXT(a_pop_starts, pop, busy && (idx == '0),
                    "popped body did not start a frame")

endmodule

[rtl/core/modbus_spindle_frame_builder.sv]
// Spindle command to Modbus RTU frame builder, top level.
// Holds the max_rpm register; uses msfb_pkg, msfb_front, msfb_fifo, msfb_back.
//
// Input channel (in_valid, in_stall, in_data): one beat is one spindle command,
// opcode 0..4 and rpm. Opcodes 5 to 7 are dropped and produce nothing.
// Output channel (out_valid, out_stall, out_data): eight beats per command,
// the six frame bytes then CRC low and CRC high; last_byte marks the CRC high.
// Configuration: cfg_we writes cfg_wdata into max_rpm (full-scale speed).
// Write it only while no command is in flight.
// Path: an accepted command is registered in the front end and pushed into the
// queue, then popped into the emitter, which registers each byte on the output;
// set speed first goes through the saturation check and the percentage divider
// (one quotient bit per cycle), which it skips when the percentage saturates.
// The emitter sends one byte per cycle unless the output stalls, with frames
// back to back. The front end takes no new command until it has pushed the last
// one, so a stream of divided set speed commands is paced by the front end.
// A queue of QUEUE_DEPTH bodies lets the front end keep accepting while the
// emitter is stalled; a stall on the output holds the current byte.
// Reset: synchronous, clears the queue and emitter and sets max_rpm to 24000.
module modbus_spindle_frame_builder import msfb_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  cmd_t        in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output frame_out_t  out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] max_rpm;
  logic        push;
  body_t       push_body;
  logic        pop;
  body_t       head;
  q_status_t   q_status;

  // Full-scale speed register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_rpm <= MAX_RPM_RESET;
    end else if (cfg_we) begin
      max_rpm <= cfg_wdata;
    end
  end

  msfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .max_rpm   (max_rpm),
    .push      (push),
    .push_body (push_body),
    .q_status  (q_status)
  );

  msfb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_body (push_body),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  msfb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[dv/modbus_spindle_frame_builder_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus RTU spindle frame builder.
// Depends only on msfb_pkg and modbus_spindle_frame_builder; frames and CRCs are predicted here.
module modbus_spindle_frame_builder_tb import msfb_pkg::*; ();

  // Opcodes outside the command set; the block drops them.
  localparam logic [2:0] OP_RSVD_5 = 3'd5;
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  // Fixed frame contents.
  localparam logic [7:0] SLAVE_ADDR    = 8'h01;
  localparam logic [7:0] FN_READ_HOLD  = 8'h03;
  localparam logic [7:0] FN_WRITE_REG  = 8'h06;
  localparam logic [7:0] REG_STATUS_HI = 8'h80;
  localparam logic [7:0] REG_CTRL_HI   = 8'h20;
  localparam logic [7:0] REG_FREQ_HI   = 8'h10;
  localparam logic [7:0] REG_FREQ_LO   = 8'h02;
  localparam logic [7:0] CTL_RUN       = 8'h01;
  localparam logic [7:0] CTL_STOP      = 8'h06;
  localparam logic [7:0] CTL_REVERSE   = 8'h02;
  localparam logic [7:0] READ_COUNT    = 8'h01;

  localparam logic [15:0] CRC_SEED           = 16'hFFFF;
  localparam logic [15:0] CRC_REFLECTED_POLY = 16'hA001;
  localparam logic [15:0] RPM_FULL_RESET     = 16'd24000;

  localparam int MAX_WAIT       = 12;
  localparam int SETTLE_CYCLES  = 24;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  cmd_t       in_data;
  logic       out_valid;
  logic       out_stall;
  frame_out_t out_data;
  logic       cfg_we;
  logic [15:0] cfg_wdata;

  frame_out_t  pending_frame_bytes[$];
  logic [15:0] model_max_rpm;
  int          error_count;
  int          idle_cycles;
  int          hold_cycles;
  bit          no_idle;

  modbus_spindle_frame_builder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Wait before a beat; zero while a back-to-back stretch is running.
  function automatic int pick_wait();
    if (no_idle) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Percentage of full scale, rounded half up, saturating at 255.
  function automatic logic [7:0] speed_pct(input logic [15:0] rpm, input logic [15:0] full);
    logic [33:0] num;
    logic [33:0] den;
    logic [33:0] quo;
    if (full == 16'd0) return 8'd255;
    num = {18'd0, rpm} * 34'd200 + {18'd0, full};
    den = {18'd0, full} << 1;
    quo = num / den;
    return (quo > 34'd255) ? 8'd255 : quo[7:0];
  endfunction

  // CRC-16/Modbus over the six body bytes, byte 0 first.
  function automatic logic [15:0] crc16_over_body(input logic [5:0][7:0] body);
    logic [15:0] acc;
    acc = CRC_SEED;
    for (int i = 0; i < 6; i++) begin
      acc = acc ^ {8'h00, body[i]};
      for (int b = 0; b < 8; b++) begin
        acc = acc[0] ? ((acc >> 1) ^ CRC_REFLECTED_POLY) : (acc >> 1);
      end
    end
    return acc;
  endfunction

  // Queues the eight bytes a command should produce; dropped opcodes queue nothing.
  task automatic queue_frame_for(input cmd_t cmd);
    logic [5:0][7:0] body;
    logic [15:0]     crc;
    frame_out_t      beat;
    body[0] = SLAVE_ADDR;
    body[1] = FN_WRITE_REG;
    body[2] = REG_CTRL_HI;
    body[3] = 8'h00;
    body[4] = 8'h00;
    case (cmd.opcode)
      OP_HEARTBEAT: begin
        body[1] = FN_READ_HOLD;
        body[2] = REG_STATUS_HI;
        body[5] = READ_COUNT;
      end
      OP_RUN:     body[5] = CTL_RUN;
      OP_STOP:    body[5] = CTL_STOP;
      OP_REVERSE: body[5] = CTL_REVERSE;
      OP_SPEED: begin
        body[2] = REG_FREQ_HI;
        body[3] = REG_FREQ_LO;
        body[4] = speed_pct(cmd.rpm, model_max_rpm);
        body[5] = 8'h00;
      end
      default: return;
    endcase
    crc = crc16_over_body(body);
    for (int k = 0; k < 8; k++) begin
      beat.frame_byte = (k < 6) ? body[k] : ((k == 6) ? crc[7:0] : crc[15:8]);
      beat.last_byte  = (k == 7);
      pending_frame_bytes.push_back(beat);
    end
  endtask

  // Sends one command beat after a random gap; valid stays high after acceptance.
  task automatic send_cmd(input logic [2:0] opcode, input logic [15:0] rpm);
    cmd_t cmd;
    int   gap;
    cmd.opcode = opcode;
    cmd.rpm    = rpm;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall !== 1'b0);
    queue_frame_for(cmd);
  endtask

  // Stops offering commands, waits for every expected byte, then lets the block settle.
  task automatic wait_quiet(input int extra);
    in_valid <= 1'b0;
    while (pending_frame_bytes.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Writes the full-scale register while the block is idle.
  task automatic write_max_rpm(input logic [15:0] value);
    wait_quiet(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_max_rpm = value;
  endtask

  function automatic void report_mismatch(input string what, input frame_out_t exp_beat,
                                          input frame_out_t act_beat);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected byte %h last %b, got byte %h last %b", $realtime, what,
               exp_beat.frame_byte, exp_beat.last_byte, act_beat.frame_byte, act_beat.last_byte);
    end
  endfunction

  // Receiver: stalls a random number of cycles per beat, or a long hold-off on request,
  // and checks each accepted beat against the oldest expected byte.
  initial begin : frame_checker
    int         n;
    frame_out_t exp_beat;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = pick_wait();
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_frame_bytes.size() == 0) begin
        exp_beat = '0;
        report_mismatch("unexpected beat", exp_beat, out_data);
      end else begin
        exp_beat = pending_frame_bytes.pop_front();
        if (out_data.frame_byte !== exp_beat.frame_byte ||
            out_data.last_byte !== exp_beat.last_byte) begin
          report_mismatch("frame byte mismatch", exp_beat, out_data);
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Every command and the rounding corners at the reset full scale; dropped opcodes too.
  task automatic test_reset_scale();
    send_cmd(OP_HEARTBEAT, 16'd0);
    send_cmd(OP_RUN, 16'hFFFF);
    send_cmd(OP_STOP, 16'h5555);
    send_cmd(OP_REVERSE, 16'hAAAA);
    send_cmd(OP_SPEED, 16'd0);
    send_cmd(OP_SPEED, 16'd119);    // just under half a percent
    send_cmd(OP_SPEED, 16'd120);    // exactly half a percent rounds up
    send_cmd(OP_SPEED, 16'd24000);  // full scale
    send_cmd(OP_SPEED, 16'd61080);  // 254.5 percent rounds to 255
    send_cmd(OP_SPEED, 16'hFFFF);   // saturates
    send_cmd(OP_RSVD_5, 16'hFFFF);
    send_cmd(OP_RSVD_6, 16'd0);
    send_cmd(OP_RSVD_7, 16'h1234);
  endtask

  // Smallest, largest and zero full scale.
  task automatic test_scale_extremes();
    write_max_rpm(16'd1);
    send_cmd(OP_SPEED, 16'd0);
    send_cmd(OP_SPEED, 16'd1);
    send_cmd(OP_SPEED, 16'd3);
    write_max_rpm(16'hFFFF);
    send_cmd(OP_SPEED, 16'hFFFF);
    send_cmd(OP_SPEED, 16'd327);
    send_cmd(OP_SPEED, 16'd328);
    // A zero full scale gives the saturated percentage.
    write_max_rpm(16'd0);
    send_cmd(OP_SPEED, 16'd100);
    send_cmd(OP_HEARTBEAT, 16'd0);
  endtask

  // Receiver holds off while commands keep coming, so the input side must stall.
  task automatic test_output_hold_off();
    write_max_rpm(RPM_FULL_RESET);
    no_idle = 1'b1;
    hold_cycles = HOLD_OFF_LEN;
    for (int i = 0; i < 10; i++) begin
      send_cmd(3'($urandom_range(0, 4)), 16'($urandom()));
    end
    no_idle = 1'b0;
    wait_quiet(0);
  endtask

  // Random commands over several full-scale settings, with back-to-back stretches.
  task automatic test_random_commands();
    int          count;
    int          pick;
    logic [2:0]  opcode;
    logic [15:0] rpm;
    int          span;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_max_rpm(16'($urandom_range(1, 65535)));
        1: write_max_rpm(16'($urandom_range(1, 200)));
        2: write_max_rpm(16'($urandom_range(1000, 30000)));
        default: write_max_rpm(16'($urandom_range(30000, 65535)));
      endcase
      span = (model_max_rpm > 16'd21845) ? 65535 : 3 * model_max_rpm;
      count = 0;
      while (count < 20) begin
        no_idle = ((count / 10) % 3 == 1);
        pick = $urandom_range(0, 11);
        if (pick == 0) begin
          opcode = 3'($urandom_range(5, 7));
        end else begin
          opcode = (pick > 6) ? OP_SPEED : 3'(pick - 2 < 0 ? 0 : pick - 2);
          count++;
        end
        rpm = $urandom_range(0, 1) ? 16'($urandom_range(0, span)) : 16'($urandom());
        send_cmd(opcode, rpm);
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    error_count   = 0;
    hold_cycles   = 0;
    no_idle       = 1'b0;
    model_max_rpm = RPM_FULL_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_scale();
    test_scale_extremes();
    test_output_hold_off();
    test_random_commands();

    wait_quiet(30);
    if (error_count == 0 && pending_frame_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
